>>> rtl/lfu_pkg.sv
// Shared types for the LFU page replacement block.
`default_nettype none
package lfu_pkg;

    // Per-frame update broadcast after a search wave
    typedef enum logic [1:0] {
        UPD_NONE = 2'd0,
        UPD_INC  = 2'd1,
        UPD_LOAD = 2'd2
    } t_upd_op;

    // Update command sent to every cell; each cell matches the slot against its own index
    typedef struct packed {
        t_upd_op    op;
        logic [3:0] slot;
    } t_upd_cmd;

    // Frame index width carried in the update command
    localparam int unsigned SlotW = 4;

endpackage
`default_nettype wire

>>> rtl/lfu_page_replacement.sv
// LFU page replacement: a chain of frame cells searched by a registered wave.
// An accepted start runs the search wave through the cell chain in S_SEARCH;
// S_UPDATE then applies the update and raises the one-cycle o_valid strobe.
// New requests are taken only in S_IDLE; busy is low again with o_valid. The
// receiver cannot stall; the result payload holds until the next result.
// Reset (synchronous, active low): all frames empty, counts and fault total zero,
// frames_in_use = 8.
`default_nettype none
module lfu_page_replacement #(
    parameter int unsigned FRAMES     = 8,
    parameter int unsigned PAGE_BITS  = 16,
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [3:0]           i_cfg_data,
    input  wire logic                 start,
    input  wire logic [PAGE_BITS-1:0] i_page_number,
    output logic                      busy,
    output logic                      o_valid,
    output logic                      o_hit,
    output logic [2:0]                o_slot,
    output logic                      o_evicted_valid,
    output logic [PAGE_BITS-1:0]      o_evicted_page,
    output logic [31:0]               o_fault_total
);

    localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_UPDATE
    } t_state;

    t_state               r_state;
    logic [IDX_W-1:0]     r_cnt;
    logic [3:0]           r_frames_in_use;
    logic [PAGE_BITS-1:0] r_page;
    logic [31:0]          r_fault;

    logic [3:0]           eff_frames;
    logic [FRAMES-1:0]    active;

    logic                  c_hit[FRAMES];
    logic [IDX_W-1:0]      c_hit_idx[FRAMES];
    logic                  c_emp[FRAMES];
    logic [IDX_W-1:0]      c_emp_idx[FRAMES];
    logic                  c_have_min[FRAMES];
    logic [COUNT_BITS-1:0] c_min_cnt[FRAMES];
    logic [IDX_W-1:0]      c_min_idx[FRAMES];
    logic [PAGE_BITS-1:0]  c_min_page[FRAMES];

    lfu_pkg::t_upd_cmd    upd;
    logic [IDX_W-1:0]     dec_slot;
    logic                 dec_evict;
    logic [31:0]          n_fault;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= 4'd8;
        end else if (i_cfg_we) begin
            r_frames_in_use <= i_cfg_data;
        end
    end

    // zero means one frame; values above FRAMES enable every cell anyway
    assign eff_frames = (r_frames_in_use == 4'd0) ? 4'd1 : r_frames_in_use;

    // cell chain
    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        assign active[g] = ({1'b0, eff_frames} > 5'(g));

        if (g == 0) begin : g_head
            lfu_cell #(
                .IDX(g), .IDX_W(IDX_W), .PAGE_BITS(PAGE_BITS), .COUNT_BITS(COUNT_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_key      (r_page),
                .i_active   (active[g]),
                .i_hit      (1'b0),
                .i_hit_idx  ('0),
                .i_emp      (1'b0),
                .i_emp_idx  ('0),
                .i_have_min (1'b0),
                .i_min_cnt  ('0),
                .i_min_idx  ('0),
                .i_min_page ('0),
                .i_upd      (upd),
                .o_hit      (c_hit[g]),
                .o_hit_idx  (c_hit_idx[g]),
                .o_emp      (c_emp[g]),
                .o_emp_idx  (c_emp_idx[g]),
                .o_have_min (c_have_min[g]),
                .o_min_cnt  (c_min_cnt[g]),
                .o_min_idx  (c_min_idx[g]),
                .o_min_page (c_min_page[g])
            );
        end else begin : g_body
            lfu_cell #(
                .IDX(g), .IDX_W(IDX_W), .PAGE_BITS(PAGE_BITS), .COUNT_BITS(COUNT_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_key      (r_page),
                .i_active   (active[g]),
                .i_hit      (c_hit[g-1]),
                .i_hit_idx  (c_hit_idx[g-1]),
                .i_emp      (c_emp[g-1]),
                .i_emp_idx  (c_emp_idx[g-1]),
                .i_have_min (c_have_min[g-1]),
                .i_min_cnt  (c_min_cnt[g-1]),
                .i_min_idx  (c_min_idx[g-1]),
                .i_min_page (c_min_page[g-1]),
                .i_upd      (upd),
                .o_hit      (c_hit[g]),
                .o_hit_idx  (c_hit_idx[g]),
                .o_emp      (c_emp[g]),
                .o_emp_idx  (c_emp_idx[g]),
                .o_have_min (c_have_min[g]),
                .o_min_cnt  (c_min_cnt[g]),
                .o_min_idx  (c_min_idx[g]),
                .o_min_page (c_min_page[g])
            );
        end
    end

    // decision from the end of the chain: hit, else first empty, else least used
    always_comb begin
        dec_evict = 1'b0;
        if (c_hit[FRAMES-1]) begin
            dec_slot = c_hit_idx[FRAMES-1];
        end else if (c_emp[FRAMES-1]) begin
            dec_slot = c_emp_idx[FRAMES-1];
        end else begin
            dec_slot  = c_min_idx[FRAMES-1];
            dec_evict = 1'b1;
        end

        upd.slot = lfu_pkg::SlotW'(dec_slot);
        if (r_state != S_UPDATE) begin
            upd.op = lfu_pkg::UPD_NONE;
        end else if (c_hit[FRAMES-1]) begin
            upd.op = lfu_pkg::UPD_INC;
        end else begin
            upd.op = lfu_pkg::UPD_LOAD;
        end

        n_fault = r_fault;
        if (!c_hit[FRAMES-1] && (r_fault != 32'hFFFF_FFFF)) begin
            n_fault = r_fault + 32'd1;
        end
    end

    // control sequencer with registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_fault <= '0;
            busy    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_SEARCH;
                        r_cnt   <= '0;
                        busy    <= 1'b1;
                    end
                end
                S_SEARCH: begin
                    if (r_cnt == IDX_W'(FRAMES - 1)) begin
                        r_state <= S_UPDATE;
                    end else begin
                        r_cnt <= r_cnt + IDX_W'(1);
                    end
                end
                S_UPDATE: begin
                    r_fault <= n_fault;
                    o_valid <= 1'b1;
                    busy    <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                    busy    <= 1'b0;
                end
            endcase
        end
    end

    // request page latch and result payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_page <= i_page_number;
        end
        if (r_state == S_UPDATE) begin
            o_hit           <= c_hit[FRAMES-1];
            o_slot          <= 3'(dec_slot);
            o_evicted_valid <= dec_evict;
            o_evicted_page  <= dec_evict ? c_min_page[FRAMES-1] : '0;
            o_fault_total   <= n_fault;
        end
    end

endmodule
`default_nettype wire

>>> rtl/lfu_cell.sv
// One frame cell of the LFU chain: frame state plus one registered search stage.
`default_nettype none
module lfu_cell #(
    parameter int unsigned IDX        = 0,
    parameter int unsigned IDX_W      = 3,
    parameter int unsigned PAGE_BITS  = 16,
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [PAGE_BITS-1:0]  i_key,
    input  wire logic                  i_active,
    // search carry from the left neighbor
    input  wire logic                  i_hit,
    input  wire logic [IDX_W-1:0]      i_hit_idx,
    input  wire logic                  i_emp,
    input  wire logic [IDX_W-1:0]      i_emp_idx,
    input  wire logic                  i_have_min,
    input  wire logic [COUNT_BITS-1:0] i_min_cnt,
    input  wire logic [IDX_W-1:0]      i_min_idx,
    input  wire logic [PAGE_BITS-1:0]  i_min_page,
    // update command
    input  wire lfu_pkg::t_upd_cmd     i_upd,
    // search carry to the right neighbor
    output logic                       o_hit,
    output logic [IDX_W-1:0]           o_hit_idx,
    output logic                       o_emp,
    output logic [IDX_W-1:0]           o_emp_idx,
    output logic                       o_have_min,
    output logic [COUNT_BITS-1:0]      o_min_cnt,
    output logic [IDX_W-1:0]           o_min_idx,
    output logic [PAGE_BITS-1:0]       o_min_page
);

    localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

    logic [PAGE_BITS-1:0]  r_page;
    logic                  r_valid;
    logic [COUNT_BITS-1:0] r_count;

    logic own_hit, own_emp, take_min, sel;

    // local contribution to the search
    assign own_hit  = i_active && r_valid && (r_page == i_key);
    assign own_emp  = i_active && !r_valid;
    assign take_min = i_active && (!i_have_min || (r_count < i_min_cnt));
    assign sel      = (i_upd.slot == lfu_pkg::SlotW'(IDX));

    // search stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_hit      <= 1'b0;
            o_emp      <= 1'b0;
            o_have_min <= 1'b0;
        end else begin
            o_hit      <= i_hit || own_hit;
            o_emp      <= i_emp || own_emp;
            o_have_min <= i_have_min || i_active;
        end
        o_hit_idx  <= i_hit ? i_hit_idx : MyIdx;
        o_emp_idx  <= i_emp ? i_emp_idx : MyIdx;
        o_min_cnt  <= take_min ? r_count : i_min_cnt;
        o_min_idx  <= take_min ? MyIdx : i_min_idx;
        o_min_page <= take_min ? r_page : i_min_page;
    end

    // frame state: valid and count reset, page written on load only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else if (sel) begin
            case (i_upd.op)
                lfu_pkg::UPD_INC: begin
                    if (r_count != {COUNT_BITS{1'b1}}) begin
                        r_count <= r_count + COUNT_BITS'(1);
                    end
                end
                lfu_pkg::UPD_LOAD: begin
                    r_valid <= 1'b1;
                    r_count <= COUNT_BITS'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (sel && (i_upd.op == lfu_pkg::UPD_LOAD)) begin
            r_page <= i_key;
        end
    end

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the LFU page replacement block: predictor, directed and random requests.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAMES      = 8;
    localparam logic [15:0] USE_MAX     = 16'hFFFF;
    localparam logic [31:0] FAULT_MAX   = 32'hFFFF_FFFF;
    localparam int          DRAIN_CYCLES = FRAMES + 4;
    localparam int          RANDOM_ITEMS = 1800;

    // One result of a page reference
    typedef struct packed {
        logic        hit;
        logic [2:0]  slot;
        logic        evicted_valid;
        logic [15:0] evicted_page;
        logic [31:0] fault_total;
    } page_result_t;

    // One row of the directed part: a register write or a page request
    typedef struct {
        bit           is_cfg;
        logic [3:0]   cfg_value;
        logic [15:0]  page;
        bit           typed;
        page_result_t result;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_data;
    logic        start;
    logic [15:0] i_page_number;
    logic        busy;
    logic        o_valid;
    logic        o_hit;
    logic [2:0]  o_slot;
    logic        o_evicted_valid;
    logic [15:0] o_evicted_page;
    logic [31:0] o_fault_total;

    // Predictor state
    logic [15:0] frame_pg  [FRAMES];
    bit          frame_vld [FRAMES];
    logic [15:0] use_cnt   [FRAMES];
    logic [31:0] faults;
    logic [3:0]  frames_cfg;

    page_result_t pending_results[$];
    stim_row_t    directed_rows[$];
    int           mismatches = 0;

    lfu_page_replacement #(
        .FRAMES     (FRAMES),
        .PAGE_BITS  (16),
        .COUNT_BITS (16)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .start           (start),
        .i_page_number   (i_page_number),
        .busy            (busy),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_total   (o_fault_total)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard limit on run time
    initial begin
        #30_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // LFU lookup and update of the predicted frame table
    function automatic page_result_t lfu_lookup(input logic [15:0] pg);
        page_result_t r;
        int           n;
        int           i;
        int           victim;
        bit           found;
        r = '0;
        found = 1'b0;
        victim = -1;
        n = (frames_cfg == 4'd0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg));
        for (i = 0; i < n; i++) begin
            if (!found && frame_vld[i] && frame_pg[i] == pg) begin
                found = 1'b1;
                victim = i;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            if (use_cnt[victim] != USE_MAX) use_cnt[victim] = use_cnt[victim] + 16'd1;
        end else begin
            // lowest empty frame first, else smallest count, lowest index on ties
            for (i = 0; i < n; i++) begin
                if (victim < 0 && !frame_vld[i]) victim = i;
            end
            if (victim < 0) begin
                victim = 0;
                for (i = 1; i < n; i++) begin
                    if (use_cnt[i] < use_cnt[victim]) victim = i;
                end
                r.evicted_valid = 1'b1;
                r.evicted_page = frame_pg[victim];
            end
            frame_pg[victim] = pg;
            frame_vld[victim] = 1'b1;
            use_cnt[victim] = 16'd1;
            if (faults != FAULT_MAX) faults = faults + 32'd1;
        end
        r.slot = 3'(victim);
        r.fault_total = faults;
        return r;
    endfunction

    function automatic void add_cfg(input logic [3:0] v);
        stim_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.cfg_value = v;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_page(input logic [15:0] pg);
        stim_row_t row;
        row = '{default: '0};
        row.page = pg;
        directed_rows.push_back(row);
    endfunction

    // Row whose result is written out by hand
    function automatic void add_typed(input logic [15:0] pg, input logic h, input logic [2:0] s,
                                      input logic ev, input logic [15:0] evp,
                                      input logic [31:0] ft);
        stim_row_t row;
        row = '{default: '0};
        row.page = pg;
        row.typed = 1'b1;
        row.result.hit = h;
        row.result.slot = s;
        row.result.evicted_valid = ev;
        row.result.evicted_page = evp;
        row.result.fault_total = ft;
        directed_rows.push_back(row);
    endfunction

    // Issue one request; gap > 0 drops start and idles after the block is ready again
    task automatic issue_page(input logic [15:0] pg, input bit typed,
                              input page_result_t typed_result, input int gap);
        page_result_t pred;
        start <= 1'b1;
        i_page_number <= pg;
        do @(posedge i_clk); while (busy);
        pred = lfu_lookup(pg);
        pending_results.push_back(typed ? typed_result : pred);
        if (gap > 0) begin
            start <= 1'b0;
            do @(posedge i_clk); while (busy);
            repeat (gap - 1) @(posedge i_clk);
        end
    endtask

    // Let every outstanding request finish
    task automatic drain;
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frames(input logic [3:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        frames_cfg = v;
        i_cfg_we <= 1'b0;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        page_result_t exp_r;
        page_result_t act_r;
        if (i_rst_n && o_valid) begin
            act_r.hit = o_hit;
            act_r.slot = o_slot;
            act_r.evicted_valid = o_evicted_valid;
            act_r.evicted_page = o_evicted_page;
            act_r.fault_total = o_fault_total;
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: unexpected result hit=%0d slot=%0d ev=%0d evp=%h faults=%0d",
                             $realtime, act_r.hit, act_r.slot, act_r.evicted_valid,
                             act_r.evicted_page, act_r.fault_total);
                mismatches++;
            end else begin
                exp_r = pending_results.pop_front();
                if (act_r.hit !== exp_r.hit || act_r.slot !== exp_r.slot ||
                    act_r.evicted_valid !== exp_r.evicted_valid ||
                    act_r.evicted_page !== exp_r.evicted_page ||
                    act_r.fault_total !== exp_r.fault_total) begin
                    if (mismatches < 10) begin
                        $display("%0t: mismatch exp hit=%0d slot=%0d ev=%0d evp=%h faults=%0d",
                                 $realtime, exp_r.hit, exp_r.slot, exp_r.evicted_valid,
                                 exp_r.evicted_page, exp_r.fault_total);
                        $display("    act hit=%0d slot=%0d ev=%0d evp=%h faults=%0d",
                                 act_r.hit, act_r.slot, act_r.evicted_valid,
                                 act_r.evicted_page, act_r.fault_total);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        page_result_t no_result;
        stim_row_t    row;
        logic [3:0]   cfg_seq[6];
        logic [15:0]  work_set[16];
        logic [15:0]  pg;
        int           phase;
        int           sent;
        int           ws_size;
        int           phase_len;
        int           k;
        bit           idle_on;

        no_result = '0;
        cfg_seq = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd5, 4'd10};
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= 4'd0;
        start <= 1'b0;
        i_page_number <= 16'd0;

        // predictor reset state
        frames_cfg = 4'd8;
        faults = 32'd0;
        for (k = 0; k < FRAMES; k++) begin
            frame_pg[k] = 16'd0;
            frame_vld[k] = 1'b0;
            use_cnt[k] = 16'd0;
        end

        // directed: fill from empty, hits, full-table replacement, then register edge cases
        add_typed(16'h0000, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd1);
        add_typed(16'hFFFF, 1'b0, 3'd1, 1'b0, 16'h0000, 32'd2);
        add_typed(16'h0000, 1'b1, 3'd0, 1'b0, 16'h0000, 32'd2);
        add_typed(16'hFFFF, 1'b1, 3'd1, 1'b0, 16'h0000, 32'd2);
        add_typed(16'hFFFF, 1'b1, 3'd1, 1'b0, 16'h0000, 32'd2);
        add_typed(16'h0001, 1'b0, 3'd2, 1'b0, 16'h0000, 32'd3);
        add_typed(16'h8000, 1'b0, 3'd3, 1'b0, 16'h0000, 32'd4);
        add_typed(16'h5555, 1'b0, 3'd4, 1'b0, 16'h0000, 32'd5);
        add_typed(16'hAAAA, 1'b0, 3'd5, 1'b0, 16'h0000, 32'd6);
        add_typed(16'h7FFF, 1'b0, 3'd6, 1'b0, 16'h0000, 32'd7);
        add_typed(16'h00FF, 1'b0, 3'd7, 1'b0, 16'h0000, 32'd8);
        add_page(16'h1234);
        add_page(16'h0001);
        add_page(16'h8000);
        // zero frames acts as one frame
        add_cfg(4'd0);
        add_page(16'h0000);
        add_page(16'h4444);
        // above the frame count saturates to all frames
        add_cfg(4'd15);
        add_page(16'h0000);
        add_page(16'hAAAA);
        // shrink: upper frames neither searched nor replaced
        add_cfg(4'd2);
        add_page(16'h7FFF);
        add_page(16'h00FF);
        // grow back: upper frames kept their pages
        add_cfg(4'd8);
        add_page(16'h5555);
        add_page(16'h7FFF);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        while (directed_rows.size() != 0) begin
            row = directed_rows.pop_front();
            if (row.is_cfg) begin
                drain();
                write_frames(row.cfg_value);
            end else begin
                issue_page(row.page, row.typed, row.result, $urandom_range(0, 4));
            end
        end

        // random phases, each with its own frame setting and working set
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            drain();
            write_frames(phase < 6 ? cfg_seq[phase] : 4'($urandom_range(0, 15)));
            ws_size = $urandom_range(1, 12);
            for (k = 0; k < 16; k++) begin
                case ($urandom_range(0, 9))
                    0: work_set[k] = 16'h0000;
                    1: work_set[k] = 16'hFFFF;
                    default: work_set[k] = 16'($urandom_range(0, 16'hFFFF));
                endcase
            end
            idle_on = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(60, 160);
            for (k = 0; k < phase_len; k++) begin
                // skewed pick from the working set gives uneven use counts
                if ($urandom_range(0, 99) < 85)
                    pg = work_set[$urandom_range(0, $urandom_range(0, ws_size - 1))];
                else
                    pg = 16'($urandom_range(0, 16'hFFFF));
                issue_page(pg, 1'b0, no_result, idle_on ? $urandom_range(0, 4) : 0);
            end
            sent += phase_len;
            phase++;
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
